// File: hw/rtl/glob_wildcard_match_top_assert.svh
// Assertion macros used by the glob matcher port checker.
// Needs a clock named clock and a reset named reset in the using scope.
`ifndef GLOB_WILDCARD_MATCH_TOP_ASSERT_SVH
`define GLOB_WILDCARD_MATCH_TOP_ASSERT_SVH

// Implication in the same cycle, ignored while reset is high.
`define GWM_ASSERT_NOW(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("glob matcher assertion failed");

// Implication into the next cycle, ignored while reset is high.
`define GWM_ASSERT_NEXT(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("glob matcher assertion failed");

// Implication into the next cycle that is also checked during reset.
`define GWM_ASSERT_ALWAYS(label, cond, prop) \
   label: assert property (@(posedge clock) (cond) |=> (prop)) \
      else $error("glob matcher assertion failed");

`endif

// File: hw/rtl/gwm_pkg.sv
// Shared types and constants of the glob wildcard matcher.
// Used by the position cells, the closure network and the top level.
package gwm_pkg;

   // Number of pattern positions; the cell row has one more for the end position.
   localparam int PATTERN_MAX = 16;
   localparam int CELL_NUM    = PATTERN_MAX + 1;
   localparam int LEN_W       = $clog2(PATTERN_MAX + 1);

   // Configuration layout.
   localparam int CSR_DATA_W    = 64;
   localparam int CSR_INDEX_W   = 2;
   localparam int PAT_LEN_W     = 5;
   localparam int CHAR_W        = 8;
   localparam int PAT_STORED    = 16;
   localparam int PAT_BITS      = PAT_STORED * CHAR_W;

   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LEN  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LOW  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_HIGH = 2'd2;

   // Input commands.
   localparam logic CMD_CHAR = 1'b0;
   localparam logic CMD_END  = 1'b1;

   // Wildcard bytes.
   localparam logic [CHAR_W-1:0] STAR_BYTE  = 8'h2A;
   localparam logic [CHAR_W-1:0] QMARK_BYTE = 8'h3F;

   // Per-cycle control that every cell sees.
   typedef struct packed {
      logic step;
      logic restart;
   } gwm_ctl_type;

endpackage

// File: hw/rtl/gwm_cell.sv
// One pattern position of the matcher: holds its active bit and hands
// an advance flag to the next cell. Depends on gwm_pkg.
module gwm_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  gwm_pkg::gwm_ctl_type          ctl,
   input  logic [gwm_pkg::CHAR_W-1:0]    ch,
   input  logic [gwm_pkg::CHAR_W-1:0]    pat_byte,
   input  logic                          in_use,
   input  logic                          is_start,
   input  logic                          closed_in,
   input  logic                          carry_in,
   output logic                          active_out,
   output logic                          star_out,
   output logic                          carry_out
);
   import gwm_pkg::*;

   logic active_ff;
   logic active_in;
   logic lit_hit;

   // Classify the pattern byte of this position.
   assign star_out  = in_use && (pat_byte == STAR_BYTE);
   assign lit_hit   = in_use && !star_out && ((pat_byte == QMARK_BYTE) || (pat_byte == ch));
   assign carry_out = closed_in && lit_hit;

   // A star keeps its position; any other hit advances to the right neighbor.
   always_comb begin
      active_in = active_ff;
      if (ctl.restart) begin
         active_in = is_start;
      end else if (ctl.step) begin
         active_in = (closed_in && star_out) || carry_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= is_start;
      end else begin
         active_ff <= active_in;
      end
   end

   assign active_out = active_ff;

endmodule

// File: hw/rtl/gwm_closure.sv
// Empty-run closure of the active set: a star lets its successor be active.
// Each output bit is formed independently from the row. Depends on gwm_pkg.
module gwm_closure (
   input  logic [gwm_pkg::CELL_NUM-1:0] active,
   input  logic [gwm_pkg::CELL_NUM-1:0] in_range,
   input  logic [gwm_pkg::CELL_NUM-1:0] star,
   output logic [gwm_pkg::CELL_NUM-1:0] closed
);
   import gwm_pkg::*;

   logic [CELL_NUM-1:0] live;
   logic                acc;
   logic                run;

   assign live = active & in_range;

   // Position k is reachable if some live position i <= k is followed by stars up to k.
   always_comb begin
      closed = '0;
      acc    = 1'b0;
      run    = 1'b1;
      for (int k = 0; k < CELL_NUM; k++) begin
         acc = 1'b0;
         run = 1'b1;
         for (int i = k; i >= 0; i--) begin
            if (i < k) begin
               run = run & star[i];
            end
            acc = acc | (run & live[i]);
         end
         closed[k] = acc;
      end
   end

endmodule

// File: hw/rtl/glob_wildcard_match_top.sv
// Glob wildcard matcher: streamed source bytes against a configured pattern.
// Usage notes:
//   The req channel carries one item per transfer: req_cmd low with a
//   source byte in req_ch, or req_cmd high to close the string.
//   The rsp channel carries one transfer per closed string; rsp_matched
//   is high when the whole source matched the whole pattern.
//   Items are taken at one per cycle while req_stall is low; the row of
//   position cells updates every active position in parallel in the cycle of the transfer.
//   A result is shown the cycle after its end item and sits in a single
//   output register, which reloads in the same cycle it is taken.
//   While a result is held and rsp_stall is high, req_stall is raised.
//   The csr port writes pattern_len (index 0) and the pattern bytes
//   (index 1 for bytes 0 to 7, index 2 for bytes 8 to 15); a write acts
//   at once, also on a string in progress.
//   Reset clears the pattern registers, leaves only the start position
//   active and empties the output register.
module glob_wildcard_match_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_cmd,
   input  logic [gwm_pkg::CHAR_W-1:0]        req_ch,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_matched,
   input  logic                              csr_wr_en,
   input  logic [gwm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [gwm_pkg::CSR_DATA_W-1:0]    csr_wr_data
);
   import gwm_pkg::*;

   logic [PAT_LEN_W-1:0]  pattern_len_ff;
   logic [CSR_DATA_W-1:0] pattern_low_ff;
   logic [CSR_DATA_W-1:0] pattern_high_ff;
   logic [PAT_BITS-1:0]   pattern_bits;
   logic [LEN_W-1:0]      eff_len;

   logic [CHAR_W-1:0]     pat_bytes [CELL_NUM];
   logic [CELL_NUM-1:0]   in_use;
   logic [CELL_NUM-1:0]   in_range;
   logic [CELL_NUM-1:0]   active;
   logic [CELL_NUM-1:0]   star;
   logic [CELL_NUM-1:0]   closed;
   logic [CELL_NUM:0]     carry;

   gwm_ctl_type           ctl;
   logic                  req_xfer;
   logic                  rsp_xfer;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic                  rsp_matched_ff;
   logic                  rsp_matched_in;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_len_ff  <= '0;
         pattern_low_ff  <= '0;
         pattern_high_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_PATTERN_LEN:  pattern_len_ff  <= csr_wr_data[PAT_LEN_W-1:0];
            CSR_PATTERN_LOW:  pattern_low_ff  <= csr_wr_data;
            CSR_PATTERN_HIGH: pattern_high_ff <= csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   // Effective length is capped at the number of positions.
   always_comb begin
      if (int'(pattern_len_ff) > PATTERN_MAX) begin
         eff_len = LEN_W'(PATTERN_MAX);
      end else begin
         eff_len = LEN_W'(pattern_len_ff);
      end
   end

   // Pattern bytes per position; positions past the stored bytes read as zero.
   assign pattern_bits = PAT_BITS'({pattern_high_ff, pattern_low_ff});

   always_comb begin
      for (int j = 0; j < CELL_NUM; j++) begin
         if (j < PAT_STORED) begin
            pat_bytes[j] = pattern_bits[CHAR_W*j +: CHAR_W];
         end else begin
            pat_bytes[j] = '0;
         end
      end
   end

   // Handshake: input waits only while a held result is stalled.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_xfer  = rsp_valid_ff && !rsp_stall;

   assign ctl.step    = req_xfer && (req_cmd == CMD_CHAR);
   assign ctl.restart = req_xfer && (req_cmd == CMD_END);

   // Row of position cells; cell j advances into cell j+1.
   assign carry[0] = 1'b0;

   for (genvar j = 0; j < CELL_NUM; j++) begin : g_cell
      assign in_use[j]   = (eff_len > LEN_W'(j));
      assign in_range[j] = (eff_len >= LEN_W'(j));

      gwm_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .ch         (req_ch),
         .pat_byte   (pat_bytes[j]),
         .in_use     (in_use[j]),
         .is_start   (j == 0),
         .closed_in  (closed[j]),
         .carry_in   (carry[j]),
         .active_out (active[j]),
         .star_out   (star[j]),
         .carry_out  (carry[j+1])
      );
   end

   gwm_closure u_closure (
      .active   (active),
      .in_range (in_range),
      .star     (star),
      .closed   (closed)
   );

   // Output register: loads on an end item, clears when its transfer completes.
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_matched_in = rsp_matched_ff;
      if (ctl.restart) begin
         rsp_valid_in   = 1'b1;
         rsp_matched_in = closed[eff_len];
      end else if (rsp_xfer) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_matched_ff <= rsp_matched_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_matched = rsp_matched_ff;

endmodule

// File: hw/rtl/gwm_checker.sv
// Port-level checker for the glob matcher, bound to the top level.
// Depends on gwm_pkg and the assertion macros header.
`include "glob_wildcard_match_top_assert.svh"

module gwm_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic                              req_cmd,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic                              rsp_matched
);
   import gwm_pkg::*;

   logic end_xfer;

   assign end_xfer = req_valid && !req_stall && (req_cmd == CMD_END);

   // A held result stays and keeps its value.
   `GWM_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid)
   `GWM_ASSERT_NEXT(a_rsp_stable, rsp_valid && rsp_stall, $stable(rsp_matched))

   // An accepted end item always produces a result in the next cycle.
   `GWM_ASSERT_NEXT(a_end_result, end_xfer, rsp_valid)

   // No input transfer while a held result is stalled.
   `GWM_ASSERT_NOW(a_no_overrun, rsp_valid && rsp_stall, req_stall)

   // The output register is empty after reset.
   `GWM_ASSERT_ALWAYS(a_reset_empty, reset, !rsp_valid)

endmodule

bind glob_wildcard_match_top gwm_checker u_gwm_checker (.*);

// File: sim/glob_wildcard_match_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the glob wildcard matcher: tracks the active pattern positions from
// the observed transfers and register writes, and checks every match result.
// Depends on gwm_pkg for widths, register indexes, commands and wildcard bytes.
module glob_wildcard_match_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic                              req_cmd,
   input  logic [gwm_pkg::CHAR_W-1:0]        req_ch,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic                              rsp_matched,
   input  logic                              csr_wr_en,
   input  logic [gwm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [gwm_pkg::CSR_DATA_W-1:0]    csr_wr_data,
   output int                                fail_count,
   output int                                results_pending,
   output int                                strings_checked,
   output int                                strings_matched
);
   import gwm_pkg::*;

   typedef logic [CELL_NUM-1:0] pos_set_type;

   // Shadow copy of the pattern registers and of the held position set.
   logic [PAT_LEN_W-1:0]  len_reg;
   logic [CSR_DATA_W-1:0] chars_low_reg;
   logic [CSR_DATA_W-1:0] chars_high_reg;
   pos_set_type           live_positions;
   logic                  match_expect_q[$];

   // Pattern byte at position i; positions past the stored bytes read as zero.
   function automatic logic [CHAR_W-1:0] pattern_byte(int unsigned i);
      if (i < 8) return chars_low_reg[CHAR_W*i +: CHAR_W];
      if (i < PAT_STORED) return chars_high_reg[CHAR_W*(i-8) +: CHAR_W];
      return '0;
   endfunction

   // A length above the number of pattern positions counts as the full row.
   function automatic int unsigned used_length();
      if (len_reg > PATTERN_MAX) return PATTERN_MAX;
      return len_reg;
   endfunction

   // Drop positions past the pattern end, then let each reachable star match nothing.
   function automatic pos_set_type with_empty_stars(pos_set_type set, int unsigned n);
      pos_set_type result;
      result = '0;
      for (int j = 0; j <= n; j++) result[j] = set[j];
      for (int j = 0; j < n; j++) begin
         if (result[j] && pattern_byte(j) == STAR_BYTE) result[j+1] = 1'b1;
      end
      return result;
   endfunction

   // One source byte: a star keeps its position, a question mark or equal byte advances.
   function automatic pos_set_type consume_byte(pos_set_type cur, int unsigned n,
                                                logic [CHAR_W-1:0] ch);
      pos_set_type result;
      logic [CHAR_W-1:0] pat;
      result = '0;
      for (int j = 0; j < n; j++) begin
         if (cur[j]) begin
            pat = pattern_byte(j);
            if (pat == STAR_BYTE) result[j] = 1'b1;
            else if (pat == QMARK_BYTE || pat == ch) result[j+1] = 1'b1;
         end
      end
      return result;
   endfunction

   always @(posedge clock) begin
      int unsigned n;
      pos_set_type cur;
      logic want;
      if (reset) begin
         len_reg = '0;
         chars_low_reg = '0;
         chars_high_reg = '0;
         live_positions = pos_set_type'(1);
         match_expect_q.delete();
      end else begin
         // Register writes act at once, also on a string in progress.
         if (csr_wr_en) begin
            case (csr_index)
               CSR_PATTERN_LEN:  len_reg = csr_wr_data[PAT_LEN_W-1:0];
               CSR_PATTERN_LOW:  chars_low_reg = csr_wr_data;
               CSR_PATTERN_HIGH: chars_high_reg = csr_wr_data;
               default: ;
            endcase
         end

         // Input transfer: advance the position set or close the string.
         if (req_valid && !req_stall) begin
            n = used_length();
            cur = with_empty_stars(live_positions, n);
            if (req_cmd == CMD_END) begin
               match_expect_q = {match_expect_q, cur[n]};
               live_positions = pos_set_type'(1);
            end else begin
               live_positions = consume_byte(cur, n, req_ch);
            end
         end

         // Result transfer: compare with the oldest expected verdict.
         if (rsp_valid && !rsp_stall) begin
            if (match_expect_q.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result, expected none, actual matched=%0b",
                        $time, rsp_matched);
            end else begin
               want = match_expect_q.pop_front();
               strings_checked++;
               if (want) strings_matched++;
               if (rsp_matched !== want) begin
                  fail_count++;
                  $display("%0t: matched mismatch, expected %0b, actual %0b",
                           $time, want, rsp_matched);
               end
            end
         end
         results_pending = match_expect_q.size();
      end
   end

endmodule

// File: sim/glob_wildcard_match_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for the glob wildcard matcher: drives patterns and source strings,
// adds random gaps and stalls, and reports the verdict from glob_wildcard_match_checker.
// Depends on gwm_pkg and on the glob_wildcard_match_top block.
module glob_wildcard_match_top_tb;
   import gwm_pkg::*;

   localparam int ITEM_TARGET   = 1600;
   localparam int LONG_HOLD     = 300;
   localparam int SETTLE_CYCLES = 4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic                   req_cmd = CMD_CHAR;
   logic [CHAR_W-1:0]      req_ch = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic                   rsp_matched;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_PATTERN_LEN;
   logic [CSR_DATA_W-1:0]  csr_wr_data = '0;

   int fail_count;
   int results_pending;
   int strings_checked;
   int strings_matched;

   // Stimulus-side view of the pattern, used only to build strings likely to match.
   logic [CHAR_W-1:0] pat_bytes [PAT_STORED];
   int unsigned       pat_len_sel;
   logic [CHAR_W-1:0] src_bytes[$];

   int   items_sent = 0;
   int   settings_used = 0;
   logic tx_gaps_on = 1'b0;
   logic rx_gaps_on = 1'b0;
   int   hold_requests = 0;
   int   hold_served = 0;
   int   stall_left = 0;

   glob_wildcard_match_top i_dut (.*);

   glob_wildcard_match_checker i_checker (.*);

   always #4 clock = ~clock;

   // Receiver: random stall bursts, plus the long hold on request.
   always @(negedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         stall_left <= LONG_HOLD;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (rx_gaps_on && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 15);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Safety net against a hung handshake.
   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wr_data = data;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // Writes all three pattern registers; the length word carries random upper bits.
   task automatic load_pattern(input int unsigned len);
      logic [CSR_DATA_W-1:0] word;
      logic [CSR_DATA_W-1:0] low_word;
      logic [CSR_DATA_W-1:0] high_word;
      word = {$urandom, $urandom};
      word[PAT_LEN_W-1:0] = len[PAT_LEN_W-1:0];
      for (int i = 0; i < 8; i++) begin
         low_word[CHAR_W*i +: CHAR_W] = pat_bytes[i];
         high_word[CHAR_W*i +: CHAR_W] = pat_bytes[i+8];
      end
      pat_len_sel = len;
      write_reg(CSR_PATTERN_LEN, word);
      write_reg(CSR_PATTERN_LOW, low_word);
      write_reg(CSR_PATTERN_HIGH, high_word);
      settings_used++;
   endtask

   // One input transfer, optionally after a random gap.
   task automatic send_item(input logic cmd, input logic [CHAR_W-1:0] ch);
      @(negedge clock);
      if (tx_gaps_on && $urandom_range(0, 5) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_cmd = cmd;
      req_ch = ch;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   // Stop offering, wait for every verdict, then give the block a few quiet cycles.
   task automatic settle();
      @(negedge clock);
      req_valid = 1'b0;
      while (results_pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic logic [CHAR_W-1:0] source_byte();
      if ($urandom_range(0, 7) == 0) return CHAR_W'($urandom_range(0, 255));
      return CHAR_W'("a" + $urandom_range(0, 2));
   endfunction

   // Builds a string from the pattern (stars expanded, marks filled), sometimes
   // damaged by one edit; otherwise a short string of random bytes.
   task automatic build_source(input logic noise_only);
      int unsigned eff;
      int unsigned pos;
      src_bytes.delete();
      eff = (pat_len_sel > PATTERN_MAX) ? PATTERN_MAX : pat_len_sel;
      if (noise_only) begin
         repeat ($urandom_range(0, 6)) src_bytes = {src_bytes, source_byte()};
      end else begin
         for (int i = 0; i < eff; i++) begin
            if (pat_bytes[i] == STAR_BYTE)
               repeat ($urandom_range(0, 3)) src_bytes = {src_bytes, source_byte()};
            else if (pat_bytes[i] == QMARK_BYTE)
               src_bytes = {src_bytes, source_byte()};
            else
               src_bytes = {src_bytes, pat_bytes[i]};
         end
         if ($urandom_range(0, 3) == 0) begin
            pos = $urandom_range(0, 2);
            if (src_bytes.size() == 0 || pos == 2) begin
               src_bytes = {src_bytes, source_byte()};
            end else if (pos == 1) begin
               void'(src_bytes.pop_back());
            end else begin
               src_bytes[$urandom_range(0, src_bytes.size() - 1)] = source_byte();
            end
         end
      end
   endtask

   task automatic send_source();
      foreach (src_bytes[i]) send_item(CMD_CHAR, src_bytes[i]);
      send_item(CMD_END, CHAR_W'($urandom_range(0, 255)));
   endtask

   initial begin
      int directed_items;
      int unsigned len;
      logic quiet;
      logic [CHAR_W-1:0] pick;

      repeat (5) @(negedge clock);
      reset = 1'b0;

      // Empty pattern straight after reset: only the empty string matches.
      send_item(CMD_END, 8'hFF);
      send_item(CMD_CHAR, "x");
      send_item(CMD_END, 8'h00);
      settle();

      // Pattern of stars only, with zero and all-ones source bytes.
      foreach (pat_bytes[i]) pat_bytes[i] = CHAR_W'($urandom_range(0, 255));
      for (int i = 0; i < 3; i++) pat_bytes[i] = STAR_BYTE;
      load_pattern(3);
      send_item(CMD_END, 8'h5A);
      send_item(CMD_CHAR, 8'h00);
      send_item(CMD_CHAR, 8'hFF);
      send_item(CMD_END, 8'hA5);
      settle();

      // Literal, mark and star together; literals are case-sensitive.
      pat_bytes[0] = "a";
      pat_bytes[1] = QMARK_BYTE;
      pat_bytes[2] = STAR_BYTE;
      pat_bytes[3] = "b";
      load_pattern(4);
      send_item(CMD_CHAR, "a");
      send_item(CMD_CHAR, 8'h00);
      send_item(CMD_CHAR, "b");
      send_item(CMD_CHAR, "b");
      send_item(CMD_END, 8'h00);
      send_item(CMD_CHAR, "A");
      send_item(CMD_CHAR, "x");
      send_item(CMD_CHAR, "b");
      send_item(CMD_END, 8'hFF);
      settle();

      // Oversized length counts as the full row; a zero pattern byte is a literal.
      // The spare register index is written too and must change nothing.
      write_reg(CSR_SPARE, {$urandom, $urandom});
      for (int i = 0; i < PAT_STORED - 1; i++) pat_bytes[i] = STAR_BYTE;
      pat_bytes[PAT_STORED-1] = 8'h00;
      load_pattern(31);
      send_item(CMD_CHAR, 8'h00);
      send_item(CMD_END, 8'h3C);
      settle();

      // Shrinking the length in mid-string drops the positions past the new end.
      pat_bytes[0] = "a";
      pat_bytes[1] = "b";
      pat_bytes[2] = STAR_BYTE;
      load_pattern(3);
      send_item(CMD_CHAR, "a");
      settle();
      load_pattern(0);
      send_item(CMD_END, 8'h00);
      settle();

      // Random patterns with strings mostly derived from them.
      directed_items = items_sent;
      for (int phase = 0; items_sent < directed_items + ITEM_TARGET; phase++) begin
         quiet = (items_sent - directed_items) > (ITEM_TARGET * 4) / 5;
         tx_gaps_on = !quiet && $urandom_range(0, 3) != 0;
         rx_gaps_on = !quiet && $urandom_range(0, 3) != 0;

         case ($urandom_range(0, 9))
            0:       len = 0;
            1:       len = PATTERN_MAX;
            2:       len = $urandom_range(PATTERN_MAX + 1, 31);
            default: len = $urandom_range(1, PATTERN_MAX - 1);
         endcase
         foreach (pat_bytes[i]) begin
            case ($urandom_range(0, 9))
               0, 1:    pick = STAR_BYTE;
               2:       pick = QMARK_BYTE;
               3:       pick = CHAR_W'($urandom_range(0, 255));
               default: pick = CHAR_W'("a" + $urandom_range(0, 2));
            endcase
            pat_bytes[i] = pick;
         end
         load_pattern(len);

         // Long receiver hold while the sender keeps offering back to back.
         if (phase == 5) begin
            tx_gaps_on = 1'b0;
            rx_gaps_on = 1'b0;
            @(posedge clock);
            hold_requests++;
            repeat (40) begin
               build_source(1'b1);
               send_source();
            end
         end

         repeat (12) begin
            build_source($urandom_range(0, 4) == 0);
            send_source();
         end
         settle();
      end

      $display("Run covered %0d items and %0d checked strings, %0d of them matching,",
               items_sent, strings_checked, strings_matched);
      $display("over %0d pattern settings with random gaps, stalls and one long hold.",
               settings_used);
      if (fail_count == 0 && results_pending == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
